// ----- design/strd_pkg.sv -----
// Shared types and constants for the shuffle table range draw block.
`timescale 1ns / 1ps

package strd_pkg;

  localparam int FUNC_W    = 2;
  localparam int RAW_IDX_W = 9;
  localparam int RANGE_W   = 16;

  localparam logic [FUNC_W-1:0] FUNC_SWAP    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_RD_A,
    S_RD_B,
    S_RD_W,
    S_WR_A,
    S_WR_B,
    S_RESTORE,
    S_DIV_SPAN,
    S_DIV_V,
    S_DONE
  } state_t;

endpackage

// ----- design/shuffle_table_range_draw.sv -----
// Permutation table with swap, restore and rejection-sampled range draw.
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  ------------------------------------------
// in       sink       in_valid/in_stall  func, index_a, index_b, range_limit
// out      source     out_valid/out_stall value, rejected
//
// Sequencing: one request at a time. A restore rewrites one entry; a swap reads
//   two entries and writes them back exchanged; a draw reads two entries, then
//   makes two passes of the shared restoring divider, one quotient bit a cycle.
//   When the depth is below 512 each swap and draw adds two passes to fold indices.
// Reset: after rst the table is rewritten to the identity, one entry a cycle,
//   and in_stall stays high until the whole table is written.
// Stalls: a finished result waits in the output register; the next request is
//   accepted meanwhile and holds in its final state only if the register is full.

module shuffle_table_range_draw
  import strd_pkg::*;
#(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [RAW_IDX_W-1:0] index_a,
  input  logic [RAW_IDX_W-1:0] index_b,
  input  logic [RANGE_W-1:0]   range_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RANGE_W-1:0]   value,
  output logic                 rejected
);

  // Table index width, and the divider's dividend width: it must hold the
  // span TABLE_DEPTH squared and a raw 9-bit index.
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SPAN_W = $clog2(TABLE_DEPTH * TABLE_DEPTH + 1);
  localparam int DVD_W  = (SPAN_W > RAW_IDX_W) ? SPAN_W : RAW_IDX_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  // Raw indices only need folding when they can reach past the table.
  localparam bit NEED_RED = (TABLE_DEPTH < (1 << RAW_IDX_W));

  localparam logic [DVD_W-1:0]   SPAN_DVD  = DVD_W'(TABLE_DEPTH * TABLE_DEPTH);
  localparam logic [DVD_W-1:0]   DEPTH_DVD = DVD_W'(TABLE_DEPTH);
  localparam logic [RANGE_W-1:0] DEPTH_DEN = RANGE_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]     DEPTH_X   = (IDX_W+1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(DVD_W);

  state_t state, state_next;

  // Request held for the duration of its work
  logic [FUNC_W-1:0]    op;
  logic [IDX_W-1:0]     ia;
  logic [IDX_W-1:0]     ib;
  logic [RAW_IDX_W-1:0] ib_raw;
  logic [RANGE_W-1:0]   rng;
  logic [IDX_W-1:0]     hi;
  logic [IDX_W-1:0]     lo;
  logic [DVD_W-1:0]     span_quo;
  logic [RANGE_W-1:0]   res_value;
  logic                 res_rej;

  // Sequencer pointers
  logic [IDX_W-1:0] clr_ptr;
  logic [IDX_W-1:0] restore_ptr;

  // Table memory
  logic [IDX_W-1:0] perm_mem [TABLE_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_rdata;

  // Shared restoring divider
  logic [DVD_W-1:0]   div_quo;
  logic [RANGE_W-1:0] div_rem;
  logic [RANGE_W-1:0] div_den;
  logic [CNT_W-1:0]   div_cnt;
  logic               div_load;
  logic [DVD_W-1:0]   div_dvd_in;
  logic [RANGE_W-1:0] div_den_in;
  logic [RANGE_W:0]   div_shift;
  logic [RANGE_W:0]   div_diff;
  logic               div_ge;
  logic               div_busy;

  logic               in_take;
  logic               out_load;
  logic [DVD_W-1:0]   draw_v;

  assign in_take  = in_valid && !in_stall;
  assign div_busy = (div_cnt != '0);

  // Combined draw value hi*TABLE_DEPTH + lo
  assign draw_v = DVD_W'(hi) * DEPTH_DVD + DVD_W'(lo);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_ptr == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_SWAP, FUNC_DRAW: state_next = NEED_RED ? S_RED_A : S_RD_A;
            FUNC_RESTORE:         state_next = S_RESTORE;
            default:              state_next = S_DONE;
          endcase
        end
      end
      S_RED_A: begin
        if (!div_busy) state_next = S_RED_B;
      end
      S_RED_B: begin
        if (!div_busy) state_next = S_RD_A;
      end
      S_RD_A:  state_next = S_RD_B;
      S_RD_B:  state_next = S_RD_W;
      S_RD_W:  state_next = (op == FUNC_SWAP) ? S_WR_A : S_DIV_SPAN;
      S_WR_A:  state_next = S_WR_B;
      S_WR_B:  state_next = S_DONE;
      S_RESTORE: state_next = S_DONE;
      S_DIV_SPAN: begin
        if (!div_busy) state_next = S_DIV_V;
      end
      S_DIV_V: begin
        if (!div_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall   = 1'b1;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ia;
    mem_wdata  = lo;
    mem_raddr  = ia;
    div_dvd_in = draw_v;
    div_den_in = rng;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = clr_ptr;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_RD_B: begin
        mem_raddr = ib;
      end
      S_WR_A: begin
        mem_we = 1'b1;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = ib;
        mem_wdata = hi;
      end
      S_RESTORE: begin
        mem_we    = 1'b1;
        mem_waddr = restore_ptr;
        mem_wdata = restore_ptr;
      end
      S_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase

    // Operands follow the pass the sequencer is about to enter
    case (state_next)
      S_RED_A: begin
        div_dvd_in = DVD_W'(index_a);
        div_den_in = DEPTH_DEN;
      end
      S_RED_B: begin
        div_dvd_in = DVD_W'(ib_raw);
        div_den_in = DEPTH_DEN;
      end
      S_DIV_SPAN: begin
        div_dvd_in = SPAN_DVD;
      end
      default: begin
      end
    endcase
  end

  // Start a divider pass on every entry into a dividing state
  assign div_load = (state_next != state) &&
                    (state_next == S_RED_A || state_next == S_RED_B ||
                     state_next == S_DIV_SPAN || state_next == S_DIV_V);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_ptr     <= '0;
      restore_ptr <= '0;
      div_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_ptr <= clr_ptr + 1'b1;
      // Advance the restore pointer, wrapping at the last entry
      if (state == S_RESTORE) begin
        restore_ptr <= (restore_ptr == LAST_IDX) ? '0 : restore_ptr + 1'b1;
      end
      if (div_load)      div_cnt <= DIV_STEPS;
      else if (div_busy) div_cnt <= div_cnt - 1'b1;
      if (out_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider datapath: one quotient bit a cycle, dividend shifted out of div_quo
  // ---------------------------------------------------------------------------
  assign div_shift = {div_rem, div_quo[DVD_W-1]};
  assign div_diff  = div_shift - {1'b0, div_den};
  assign div_ge    = (div_shift >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_quo <= div_dvd_in;
      div_rem <= '0;
      div_den <= div_den_in;
    end else if (div_busy) begin
      div_quo <= {div_quo[DVD_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[RANGE_W-1:0] : div_shift[RANGE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Request and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      op        <= func;
      ia        <= IDX_W'(index_a);
      ib        <= IDX_W'(index_b);
      ib_raw    <= index_b;
      // A zero range behaves as a range of one
      rng       <= (range_limit == '0) ? RANGE_W'(1) : range_limit;
      res_value <= '0;
      res_rej   <= 1'b0;
    end
    case (state)
      S_RED_A: begin
        if (!div_busy) ia <= div_rem[IDX_W-1:0];
      end
      S_RED_B: begin
        if (!div_busy) ib <= div_rem[IDX_W-1:0];
      end
      S_RD_B:  hi <= mem_rdata;
      S_RD_W:  lo <= mem_rdata;
      S_DIV_SPAN: begin
        if (!div_busy) span_quo <= div_quo;
      end
      S_DIV_V: begin
        // Reject when v lies at or above floor(span/range)*range, that is
        // when floor(v/range) reaches floor(span/range)
        if (!div_busy) begin
          if (div_quo >= span_quo) begin
            res_rej   <= 1'b1;
            res_value <= '0;
          end else begin
            res_rej   <= 1'b0;
            res_value <= div_rem;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      value    <= res_value;
      rejected <= res_rej;
    end
  end

  // ---------------------------------------------------------------------------
  // Permutation table
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) perm_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= perm_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_idle_on_load : assert property (@(posedge clk) disable iff (rst)
    div_load |-> !div_busy)
    else $error("divider restarted while a pass was running");

  a_restore_ptr_hold : assert property (@(posedge clk) disable iff (rst)
    (state != S_RESTORE) |=> $stable(restore_ptr))
    else $error("restore pointer moved outside a restore request");

  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> (value == '0))
    else $error("rejected draw carries a non-zero value");

  a_index_in_table : assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_A) |-> (({1'b0, ia} < DEPTH_X) && ({1'b0, ib} < DEPTH_X)))
    else $error("table index beyond depth at read");

endmodule

// ----- bench/shuffle_table_range_draw_tb.sv -----
// Self-checking bench for the shuffle table range draw block: directed rows, then random requests.
`timescale 1ns / 1ps

module shuffle_table_range_draw_tb
  import strd_pkg::*;
();

  // Function code that the block must ignore: no table change, zero result.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int DEPTH       = 512;
  localparam int SPAN        = DEPTH * DEPTH;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back the block up
  localparam int DRAIN_WAIT  = 100;   // idle wait after the last owed result is taken
  localparam int PHASE_ITEMS = 90;

  // One row of the directed plan. Where typed is set, the result is written in
  // by hand; otherwise the row is checked against the table mirror below.
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [RAW_IDX_W-1:0] ia;
    logic [RAW_IDX_W-1:0] ib;
    logic [RANGE_W-1:0]   rl;
    logic [9:0]           count;
    logic                 typed;
    logic [RANGE_W-1:0]   value;
    logic                 rejected;
  } step_t;

  typedef struct packed {
    logic [RANGE_W-1:0] value;
    logic               rejected;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic [RAW_IDX_W-1:0] index_a;
  logic [RAW_IDX_W-1:0] index_b;
  logic [RANGE_W-1:0]   range_limit;
  logic                 out_valid;
  logic                 out_stall;
  logic [RANGE_W-1:0]   value;
  logic                 rejected;

  // Mirror of the block's permutation table and restore pointer.
  logic [RAW_IDX_W-1:0] perm_copy [DEPTH];
  logic [RAW_IDX_W-1:0] restore_at;

  outcome_t owed_outcomes [$];
  step_t    plan [23];

  int mismatch_count;
  int quiet_cycles;
  int send_idle;
  int recv_idle;
  bit hold_go;

  shuffle_table_range_draw u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .index_a     (index_a),
    .index_b     (index_b),
    .range_limit (range_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .rejected    (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the mirror and return the result it owes.
  function automatic outcome_t table_apply(input logic [FUNC_W-1:0] f,
                                           input logic [RAW_IDX_W-1:0] ia,
                                           input logic [RAW_IDX_W-1:0] ib,
                                           input logic [RANGE_W-1:0] rl);
    outcome_t             o;
    logic [RAW_IDX_W-1:0] t;
    int unsigned          v;
    int unsigned          rng;
    int unsigned          zone;
    o = '0;
    case (f)
      FUNC_SWAP: begin
        t             = perm_copy[ia];
        perm_copy[ia] = perm_copy[ib];
        perm_copy[ib] = t;
      end
      FUNC_DRAW: begin
        // hi*512 + lo is just the two entries side by side
        v    = 32'({perm_copy[ia], perm_copy[ib]});
        rng  = (rl == '0) ? 32'd1 : 32'(rl);
        // values at or above the last whole multiple of the range are biased
        zone = (SPAN / rng) * rng;
        if (v >= zone) begin
          o.rejected = 1'b1;
        end else begin
          o.value = RANGE_W'(v % rng);
        end
      end
      FUNC_RESTORE: begin
        perm_copy[restore_at] = restore_at;
        restore_at            = restore_at + 1'b1;  // wraps at the table depth
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Offer one request, wait for the handshake, then log what it owes.
  task automatic send_request(input logic [FUNC_W-1:0] f,
                              input logic [RAW_IDX_W-1:0] ia,
                              input logic [RAW_IDX_W-1:0] ib,
                              input logic [RANGE_W-1:0] rl,
                              input logic typed,
                              input logic [RANGE_W-1:0] tv,
                              input logic tr);
    outcome_t o;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    index_a     <= ia;
    index_b     <= ib;
    range_limit <= rl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = table_apply(f, ia, ib, rl);
    if (typed) begin
      o.value    = tv;
      o.rejected = tr;
    end
    owed_outcomes.push_back(o);
  endtask

  // Mostly draws and swaps on a shuffled table, with odd restores and
  // unused codes.
  task automatic random_requests(input int n);
    int                 issued;
    int                 pick;
    logic [FUNC_W-1:0]  f;
    logic [RANGE_W-1:0] rl;
    issued = 0;
    while (issued < n) begin
      pick = $urandom_range(999);
      case ($urandom_range(9))
        0, 1:    rl = RANGE_W'($urandom_range(16, 1));
        2, 3:    rl = RANGE_W'($urandom);
        4:       rl = RANGE_W'($urandom_range(65535, 65000));
        5:       rl = RANGE_W'(1 << $urandom_range(15));
        6:       rl = '0;
        default: rl = RANGE_W'($urandom_range(1000, 1));
      endcase
      if (pick < 500)      f = FUNC_DRAW;
      else if (pick < 880) f = FUNC_SWAP;
      else if (pick < 950) f = FUNC_RESTORE;
      else                 f = FUNC_UNUSED;
      send_request(f, RAW_IDX_W'($urandom), RAW_IDX_W'($urandom), rl,
                   1'b0, '0, 1'b0);
      issued++;
    end
  endtask

  // Receiver: stall at random, and once hold off for a long stretch so the
  // block fills up and pushes back on its input.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    outcome_t o;
    if (!rst && out_valid && !out_stall) begin
      if (owed_outcomes.size() == 0) begin
        $error("unexpected result: value %0d rejected %0d", value, rejected);
        mismatch_count++;
      end else begin
        o = owed_outcomes.pop_front();
        if (value !== o.value) begin
          $error("value: expected %0d, got %0d", o.value, value);
          mismatch_count++;
        end
        if (rejected !== o.rejected) begin
          $error("rejected: expected %0d, got %0d", o.rejected, rejected);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = FUNC_SWAP;
    index_a        = '0;
    index_b        = '0;
    range_limit    = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    hold_go        = 1'b0;
    send_idle      = 20;
    recv_idle      = 64;
    restore_at     = '0;
    for (int i = 0; i < DEPTH; i++) perm_copy[i] = RAW_IDX_W'(i);

    // Rows with results typed in rely on the identity table, so keep them
    // ahead of the first swap or behind a full restore.
    plan = '{
      // identity table: extremes of indices and range
      '{FUNC_DRAW,      9'd0,   9'd0,   16'd1,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd0,   9'd0,   16'd65535, 10'd1,   1'b1, 16'd0,     1'b0},
      // top of the span lands in the rejection zone
      '{FUNC_DRAW,      9'd511, 9'd511, 16'd65535, 10'd1,   1'b1, 16'd0,     1'b1},
      '{FUNC_DRAW,      9'd511, 9'd511, 16'd1,     10'd1,   1'b1, 16'd0,     1'b0},
      // zero range behaves as one
      '{FUNC_DRAW,      9'd3,   9'd7,   16'd0,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd0,   9'd5,   16'd7,     10'd1,   1'b1, 16'd5,     1'b0},
      '{FUNC_DRAW,      9'd1,   9'd0,   16'd65535, 10'd1,   1'b1, 16'd512,   1'b0},
      '{FUNC_DRAW,      9'd511, 9'd0,   16'd65535, 10'd1,   1'b1, 16'd65027, 1'b0},
      '{FUNC_DRAW,      9'd511, 9'd511, 16'd2,     10'd1,   1'b1, 16'd1,     1'b0},
      '{FUNC_DRAW,      9'd255, 9'd256, 16'd1000,  10'd1,   1'b1, 16'd816,   1'b0},
      // unused code changes nothing
      '{FUNC_UNUSED,    9'd511, 9'd511, 16'd65535, 10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_SWAP,      9'd0,   9'd511, 16'd0,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd0,   9'd511, 16'd65535, 10'd1,   1'b0, 16'd0,     1'b0},
      // swap of an entry with itself
      '{FUNC_SWAP,      9'd5,   9'd5,   16'd0,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd5,   9'd0,   16'd60000, 10'd1,   1'b0, 16'd0,     1'b0},
      '{FUNC_SWAP,      9'd100, 9'd200, 16'd0,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd100, 9'd200, 16'd65521, 10'd1,   1'b0, 16'd0,     1'b0},
      // full restore: one request per entry, pointer ends back at zero
      '{FUNC_RESTORE,   9'd0,   9'd0,   16'd0,     10'd512, 1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd511, 9'd0,   16'd65535, 10'd1,   1'b1, 16'd65027, 1'b0},
      '{FUNC_RESTORE,   9'd511, 9'd511, 16'd65535, 10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd200, 9'd100, 16'd0,     10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_SWAP,      9'd511, 9'd1,   16'd65535, 10'd1,   1'b1, 16'd0,     1'b0},
      '{FUNC_DRAW,      9'd1,   9'd511, 16'd3,     10'd1,   1'b0, 16'd0,     1'b0}
    };

    // Hold reset, then release it; the block then clears its table on its own
    // with in_stall high, which the first handshake simply waits out.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    foreach (plan[r]) begin
      repeat (plan[r].count) begin
        send_request(plan[r].func, plan[r].ia, plan[r].ib, plan[r].rl,
                     plan[r].typed, plan[r].value, plan[r].rejected);
      end
    end
    random_requests(PHASE_ITEMS);

    // Swap the idling round.
    send_idle = 64;
    recv_idle = 20;
    random_requests(PHASE_ITEMS);

    // No idling, but start with the long receiver hold-off.
    send_idle = 0;
    recv_idle = 0;
    hold_go   = 1'b1;
    random_requests(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain whatever is still owed; the watchdog covers a hang here.
    while (owed_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && owed_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
